>>> rtl/tta_pkg.sv
package tta_pkg;

   // field widths
   localparam int IDX_W      = 12;
   localparam int POS_W      = 48;
   localparam int UV_W       = 32;
   localparam int COMP_W     = 16;
   localparam int UNIT_SHIFT = 14;

   // front-end arithmetic
   localparam int DELTA_W = 17;
   localparam int PROD_W  = 34;
   localparam int RAW_W   = 36;

   // normaliser
   localparam int NORM_TOP   = 21;
   localparam int NORM_BOT   = 20;
   localparam int COARSE     = 8;
   localparam int M_W        = 21;
   localparam int SQ_W       = 44;
   localparam int LEN_W      = 22;
   localparam int NUM_W      = 36;
   localparam int Q_W        = 15;
   localparam int ROOT_STEPS = 22;

   // defaults for top-level parameters
   localparam int VERTEX_DEPTH_DEF = 4096;
   localparam int COUNT_BITS_DEF   = 16;

   // normaliser source select
   localparam logic NSEL_RAW = 1'b0;
   localparam logic NSEL_SUM = 1'b1;

   // corner codes
   localparam logic [1:0] CORNER_A = 2'd0;
   localparam logic [1:0] CORNER_B = 2'd1;
   localparam logic [1:0] CORNER_C = 2'd2;

   typedef struct packed {
      logic [IDX_W-1:0] index_a;
      logic [IDX_W-1:0] index_b;
      logic [IDX_W-1:0] index_c;
      logic [POS_W-1:0] position_a;
      logic [POS_W-1:0] position_b;
      logic [POS_W-1:0] position_c;
      logic [UV_W-1:0]  uv_a;
      logic [UV_W-1:0]  uv_b;
      logic [UV_W-1:0]  uv_c;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]         vertex_index;
      logic signed [COMP_W-1:0] tangent_x;
      logic signed [COMP_W-1:0] tangent_y;
      logic signed [COMP_W-1:0] tangent_z;
      logic                     degenerate;
      logic                     last_corner;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       delta;
      logic       prod;
      logic       raw;
      logic       norm_start;
      logic       norm_sel;
      logic       unit_save;
      logic       blend_mul;
      logic       blend_sum;
      logic       cor_save;
      logic       cor_bad;
      logic       emit;
      logic       clr_step;
      logic [1:0] corner;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic norm_done;
      logic tri_ok;
      logic rsp_free;
   } stat_type;

endpackage

>>> rtl/triangle_tangent_accumulator.sv
// Triangle tangent accumulator.
// req channel: one beat carries a whole triangle (three indices, positions, UVs).
//   An input beat is taken when req_valid is high and req_stall low.
// rsp channel: three beats per triangle, corners a, b, c in order; last_corner
//   marks the third. A beat is taken when rsp_valid is high and rsp_stall low.
// Passes: a non-degenerate triangle makes four passes through one shared
//   iterative normaliser (shift, three squares, 22-step square root, 15-step
//   divide), a degenerate one only the first; the length of a pass depends
//   on how far the magnitudes must be shifted.
//   req_stall drops again once the third beat is loaded into the output
//   register, so the next triangle starts while that beat is still waiting.
// Reset: a clearing pass writes zero to every store entry, one per cycle,
//   with req_stall held high throughout.
// Back-pressure: with rsp_stall high the result register holds its beat and
//   the sequencer waits before loading the next beat; the store is only written as
//   its beat is loaded, so later triangles always see earlier updates.
module triangle_tangent_accumulator #(
   parameter int VERTEX_DEPTH = tta_pkg::VERTEX_DEPTH_DEF,
   parameter int COUNT_BITS   = tta_pkg::COUNT_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tta_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tta_pkg::rsp_type rsp_data
);

   tta_pkg::cmd_type  cmd;
   tta_pkg::stat_type stat;

   // sequencer: one triangle at a time, corners in order
   tta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // datapath: deltas, normaliser, tangent/count store, result register
   tta_dp #(
      .VERTEX_DEPTH (VERTEX_DEPTH),
      .COUNT_BITS   (COUNT_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/tta_norm.sv
module tta_norm #(
   parameter int VW = tta_pkg::RAW_W
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [2:0][VW-1:0]                    v_in,
   output logic                                  done,
   output logic                                  ok,
   output logic [2:0][tta_pkg::COMP_W-1:0]       o
);

   localparam int CW = tta_pkg::COMP_W;
   localparam int SQW = tta_pkg::SQ_W;
   localparam int NW = tta_pkg::NUM_W;
   localparam int QW = tta_pkg::Q_W;
   localparam int MW = tta_pkg::M_W;
   localparam int LW = tta_pkg::LEN_W;
   localparam int TOP = tta_pkg::NORM_TOP;
   localparam int BOT = tta_pkg::NORM_BOT;
   localparam int CRS = tta_pkg::COARSE;

   localparam logic [2:0] P_IDLE  = 3'd0;
   localparam logic [2:0] P_SHIFT = 3'd1;
   localparam logic [2:0] P_SQ    = 3'd2;
   localparam logic [2:0] P_ROOT  = 3'd3;
   localparam logic [2:0] P_DIVI  = 3'd4;
   localparam logic [2:0] P_DIV   = 3'd5;

   logic [2:0]              phase_ff, phase_in;
   logic [4:0]              cnt_ff, cnt_in;
   logic [2:0][VW-1:0]      m_ff, m_in;
   logic [2:0]              neg_ff, neg_in;
   logic [SQW-1:0]          acc_ff, acc_in;
   logic [SQW-1:0]          rem_ff, rem_in;
   logic [SQW:0]            root_ff, root_in;
   logic [SQW:0]            bit_ff, bit_in;
   logic [2:0][NW-1:0]      num_ff, num_in;
   logic [2:0][QW-1:0]      q_ff, q_in;
   logic                    done_ff, done_in;
   logic                    ok_ff, ok_in;
   logic [2:0][CW-1:0]      o_ff, o_in;

   logic [VW-1:0]           orv;
   logic [MW-1:0]           m_sel;
   logic [2*MW-1:0]         sq;
   logic [SQW:0]            trial;
   logic [LW-1:0]           len;
   logic [NW-1:0]           dvs;

   assign orv   = m_ff[0] | m_ff[1] | m_ff[2];
   assign m_sel = m_ff[cnt_ff[1:0]][MW-1:0];
   assign sq    = (2*MW)'(m_sel) * (2*MW)'(m_sel);
   assign trial = root_ff + bit_ff;
   assign len   = root_ff[LW-1:0];
   assign dvs   = NW'(len) << cnt_ff[3:0];

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      m_in     = m_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      num_in   = num_ff;
      q_in     = q_ff;
      done_in  = 1'b0;
      ok_in    = ok_ff;
      o_in     = o_ff;
      unique case (phase_ff)
         P_IDLE: begin
            if (start) begin
               for (int i = 0; i < 3; i++) begin
                  neg_in[i] = v_in[i][VW-1];
                  m_in[i]   = v_in[i][VW-1] ? (~v_in[i] + 1'b1) : v_in[i];
               end
               phase_in = P_SHIFT;
            end
         end
         P_SHIFT: begin
            if (orv == '0) begin
               ok_in    = 1'b0;
               done_in  = 1'b1;
               phase_in = P_IDLE;
            end else if (|orv[VW-1:TOP+CRS]) begin
               for (int i = 0; i < 3; i++) m_in[i] = m_ff[i] >> CRS;
            end else if (|orv[VW-1:TOP]) begin
               for (int i = 0; i < 3; i++) m_in[i] = m_ff[i] >> 1;
            end else if (!(|orv[VW-1:BOT-CRS])) begin
               for (int i = 0; i < 3; i++) m_in[i] = m_ff[i] << CRS;
            end else if (!(|orv[VW-1:BOT])) begin
               for (int i = 0; i < 3; i++) m_in[i] = m_ff[i] << 1;
            end else begin
               cnt_in   = '0;
               acc_in   = '0;
               phase_in = P_SQ;
            end
         end
         P_SQ: begin
            acc_in = acc_ff + SQW'(sq);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd2) begin
               rem_in   = acc_ff + SQW'(sq);
               root_in  = '0;
               bit_in   = (SQW+1)'(1) << (2*tta_pkg::ROOT_STEPS - 2);
               cnt_in   = '0;
               phase_in = P_ROOT;
            end
         end
         P_ROOT: begin
            if ({1'b0, rem_ff} >= trial) begin
               rem_in  = rem_ff - trial[SQW-1:0];
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'(tta_pkg::ROOT_STEPS - 1)) phase_in = P_DIVI;
         end
         P_DIVI: begin
            for (int i = 0; i < 3; i++)
               num_in[i] = NW'({m_ff[i][MW-1:0], {tta_pkg::UNIT_SHIFT{1'b0}}})
                  + NW'(len >> 1);
            q_in     = '0;
            cnt_in   = 5'(QW - 1);
            phase_in = P_DIV;
         end
         P_DIV: begin
            for (int i = 0; i < 3; i++) begin
               if (num_ff[i] >= dvs) begin
                  num_in[i]            = num_ff[i] - dvs;
                  q_in[i][cnt_ff[3:0]] = 1'b1;
               end
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               for (int i = 0; i < 3; i++)
                  o_in[i] = neg_ff[i] ? (~CW'(q_in[i]) + 1'b1) : CW'(q_in[i]);
               ok_in    = 1'b1;
               done_in  = 1'b1;
               phase_in = P_IDLE;
            end
         end
         default: phase_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      m_ff    <= m_in;
      neg_ff  <= neg_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      num_ff  <= num_in;
      q_ff    <= q_in;
      ok_ff   <= ok_in;
      o_ff    <= o_in;
   end

   assign done = done_ff;
   assign ok   = ok_ff;
   assign o    = o_ff;

endmodule

>>> rtl/tta_dp.sv
module tta_dp #(
   parameter int VERTEX_DEPTH = tta_pkg::VERTEX_DEPTH_DEF,
   parameter int COUNT_BITS   = tta_pkg::COUNT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  tta_pkg::req_type  req_data,
   input  tta_pkg::cmd_type  cmd,
   output tta_pkg::stat_type stat,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output tta_pkg::rsp_type  rsp_data
);

   localparam int AW    = $clog2(VERTEX_DEPTH);
   localparam int CW    = tta_pkg::COMP_W;
   localparam int TW    = 3 * CW;
   localparam int MEM_W = TW + COUNT_BITS;
   localparam int DW    = tta_pkg::DELTA_W;
   localparam int PW    = tta_pkg::PROD_W;
   localparam int RW    = tta_pkg::RAW_W;
   localparam int BP_W  = CW + COUNT_BITS + 1;
   localparam int SUM_W = BP_W + 1;
   localparam int NV_W  = (SUM_W > RW) ? SUM_W : RW;
   localparam int IW    = tta_pkg::IDX_W;

   tta_pkg::req_type  req_ff;
   tta_pkg::rsp_type  rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic signed [DW-1:0]    e1_ff [3], e1_in [3], e2_ff [3], e2_in [3];
   logic signed [DW-1:0]    du1_ff, du1_in, dv1_ff, dv1_in, du2_ff, du2_in, dv2_ff, dv2_in;
   logic signed [PW-1:0]    p1_ff [3], p1_in [3], p2_ff [3], p2_in [3];
   logic signed [PW-1:0]    pd1_ff, pd1_in, pd2_ff, pd2_in;
   logic signed [RW-1:0]    raw_ff [3], raw_in [3];
   logic signed [RW-1:0]    rdiff [3];
   logic signed [RW-1:0]    det_c;
   logic                    det_zero_ff, det_zero_in;
   logic                    tri_ok_ff, tri_ok_in;
   logic [2:0][CW-1:0]      unit_ff;
   logic signed [BP_W-1:0]  bprod_ff [3], bprod_in [3];
   logic signed [SUM_W-1:0] sum_ff [3], sum_in [3];
   logic signed [CW-1:0]    old_c [3];
   logic [COUNT_BITS-1:0]   cnt_c, cnt_new;
   logic                    cor_ok_ff, cor_ok_in;
   logic [2:0][CW-1:0]      cor_t_ff;

   logic [2:0][NV_W-1:0]    nv;
   logic                    n_done, n_ok;
   logic [2:0][CW-1:0]      n_o;

   logic [MEM_W-1:0]        mem_ff [VERTEX_DEPTH];
   logic [MEM_W-1:0]        rd_ff;
   logic [AW-1:0]           clr_ff, clr_in;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [MEM_W-1:0]        wr_data;
   logic [IW-1:0]           idx_k;
   logic [AW-1:0]           slot;

   // front end: deltas, products, raw tangent
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         e1_in[a] = DW'($signed(req_ff.position_b[a*CW +: CW]))
            - DW'($signed(req_ff.position_a[a*CW +: CW]));
         e2_in[a] = DW'($signed(req_ff.position_c[a*CW +: CW]))
            - DW'($signed(req_ff.position_a[a*CW +: CW]));
         p1_in[a] = dv2_ff * e1_ff[a];
         p2_in[a] = dv1_ff * e2_ff[a];
      end
      du1_in = DW'($signed(req_ff.uv_b[CW-1:0])) - DW'($signed(req_ff.uv_a[CW-1:0]));
      dv1_in = DW'($signed(req_ff.uv_b[2*CW-1:CW])) - DW'($signed(req_ff.uv_a[2*CW-1:CW]));
      du2_in = DW'($signed(req_ff.uv_c[CW-1:0])) - DW'($signed(req_ff.uv_a[CW-1:0]));
      dv2_in = DW'($signed(req_ff.uv_c[2*CW-1:CW])) - DW'($signed(req_ff.uv_a[2*CW-1:CW]));
      pd1_in = du1_ff * dv2_ff;
      pd2_in = du2_ff * dv1_ff;
      det_c  = RW'(pd1_ff) - RW'(pd2_ff);
      det_zero_in = (det_c == '0);
      for (int a = 0; a < 3; a++) begin
         rdiff[a]  = RW'(p1_ff[a]) - RW'(p2_ff[a]);
         raw_in[a] = det_c[RW-1] ? -rdiff[a] : rdiff[a];
      end
   end

   // blend of stored tangent with new unit tangent
   always_comb begin
      cnt_c = rd_ff[MEM_W-1:TW];
      for (int a = 0; a < 3; a++) begin
         old_c[a]    = $signed(rd_ff[a*CW +: CW]);
         bprod_in[a] = old_c[a] * $signed({1'b0, cnt_c});
         sum_in[a]   = SUM_W'(bprod_ff[a]) + SUM_W'($signed(unit_ff[a]));
         nv[a]       = (cmd.norm_sel == tta_pkg::NSEL_SUM) ? NV_W'(sum_ff[a])
                                                           : NV_W'(raw_ff[a]);
      end
      cnt_new   = (cnt_c == '1) ? cnt_c : cnt_c + 1'b1;
      tri_ok_in = n_ok && !det_zero_ff;
      cor_ok_in = cmd.cor_save ? n_ok : 1'b0;
   end

   tta_norm #(.VW(NV_W)) u_norm (
      .clock (clock),
      .reset (reset),
      .start (cmd.norm_start),
      .v_in  (nv),
      .done  (n_done),
      .ok    (n_ok),
      .o     (n_o)
   );

   // store addressing, index wraps modulo the depth
   always_comb begin
      case (cmd.corner)
         tta_pkg::CORNER_A: idx_k = req_ff.index_a;
         tta_pkg::CORNER_B: idx_k = req_ff.index_b;
         default:           idx_k = req_ff.index_c;
      endcase
   end

   if (VERTEX_DEPTH >= (1 << IW)) begin : g_direct
      assign slot = AW'(idx_k);
   end else begin : g_wrap
      localparam int RECIP = ((1 << 24) + VERTEX_DEPTH - 1) / VERTEX_DEPTH;
      logic [32:0] sl_prod;
      logic [20:0] sl_qd;
      logic [20:0] sl_rem;
      assign sl_prod = {21'b0, idx_k} * 33'(RECIP);
      assign sl_qd   = {12'b0, sl_prod[32:24]} * 21'(VERTEX_DEPTH);
      assign sl_rem  = {9'b0, idx_k} - sl_qd;
      assign slot    = sl_rem[AW-1:0];
   end

   assign clr_in  = clr_ff + 1'b1;
   assign wr_en   = cmd.clr_step || (cmd.emit && cor_ok_ff);
   assign wr_addr = cmd.clr_step ? clr_ff : slot;
   assign wr_data = cmd.clr_step ? '0 : {cnt_new, cor_t_ff[2], cor_t_ff[1], cor_t_ff[0]};

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem_ff[slot];
   end

   // result register
   always_comb begin
      rsp_in.vertex_index = idx_k;
      rsp_in.tangent_x    = cor_ok_ff ? cor_t_ff[0] : rd_ff[CW-1:0];
      rsp_in.tangent_y    = cor_ok_ff ? cor_t_ff[1] : rd_ff[2*CW-1:CW];
      rsp_in.tangent_z    = cor_ok_ff ? cor_t_ff[2] : rd_ff[3*CW-1:2*CW];
      rsp_in.degenerate   = !cor_ok_ff;
      rsp_in.last_corner  = (cmd.corner == tta_pkg::CORNER_C);
      if (cmd.emit)
         rsp_valid_in = 1'b1;
      else if (!rsp_stall)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.clr_step) clr_ff <= clr_in;
      end
      if (cmd.load) req_ff <= req_data;
      if (cmd.delta) begin
         e1_ff  <= e1_in;
         e2_ff  <= e2_in;
         du1_ff <= du1_in;
         dv1_ff <= dv1_in;
         du2_ff <= du2_in;
         dv2_ff <= dv2_in;
      end
      if (cmd.prod) begin
         p1_ff  <= p1_in;
         p2_ff  <= p2_in;
         pd1_ff <= pd1_in;
         pd2_ff <= pd2_in;
      end
      if (cmd.raw) begin
         raw_ff      <= raw_in;
         det_zero_ff <= det_zero_in;
      end
      if (cmd.unit_save) begin
         tri_ok_ff <= tri_ok_in;
         unit_ff   <= n_o;
      end
      if (cmd.blend_mul) bprod_ff <= bprod_in;
      if (cmd.blend_sum) sum_ff <= sum_in;
      if (cmd.cor_save || cmd.cor_bad) cor_ok_ff <= cor_ok_in;
      if (cmd.cor_save) cor_t_ff <= n_o;
      if (cmd.emit) rsp_ff <= rsp_in;
   end

   assign stat.clr_last  = (clr_ff == AW'(VERTEX_DEPTH - 1));
   assign stat.norm_done = n_done;
   assign stat.tri_ok    = tri_ok_ff;
   assign stat.rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/tta_ctrl.sv
module tta_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output tta_pkg::cmd_type  cmd,
   input  tta_pkg::stat_type stat
);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_DELTA  = 4'd2;
   localparam logic [3:0] S_PROD   = 4'd3;
   localparam logic [3:0] S_RAW    = 4'd4;
   localparam logic [3:0] S_NORM_T = 4'd5;
   localparam logic [3:0] S_WAIT_T = 4'd6;
   localparam logic [3:0] S_RD     = 4'd7;
   localparam logic [3:0] S_RDW    = 4'd8;
   localparam logic [3:0] S_SUM    = 4'd9;
   localparam logic [3:0] S_NORM_C = 4'd10;
   localparam logic [3:0] S_WAIT_C = 4'd11;
   localparam logic [3:0] S_EMIT   = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [1:0] corner_ff, corner_in;
   logic       accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in  = state_ff;
      corner_in = corner_ff;
      cmd       = '0;
      cmd.corner = corner_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = S_DELTA;
            end
         end
         S_DELTA: begin
            cmd.delta = 1'b1;
            state_in  = S_PROD;
         end
         S_PROD: begin
            cmd.prod = 1'b1;
            state_in = S_RAW;
         end
         S_RAW: begin
            cmd.raw  = 1'b1;
            state_in = S_NORM_T;
         end
         S_NORM_T: begin
            cmd.norm_start = 1'b1;
            cmd.norm_sel   = tta_pkg::NSEL_RAW;
            state_in       = S_WAIT_T;
         end
         S_WAIT_T: begin
            if (stat.norm_done) begin
               cmd.unit_save = 1'b1;
               corner_in     = tta_pkg::CORNER_A;
               state_in      = S_RD;
            end
         end
         S_RD: state_in = S_RDW;
         S_RDW: begin
            if (stat.tri_ok) begin
               cmd.blend_mul = 1'b1;
               state_in      = S_SUM;
            end else begin
               cmd.cor_bad = 1'b1;
               state_in    = S_EMIT;
            end
         end
         S_SUM: begin
            cmd.blend_sum = 1'b1;
            state_in      = S_NORM_C;
         end
         S_NORM_C: begin
            cmd.norm_start = 1'b1;
            cmd.norm_sel   = tta_pkg::NSEL_SUM;
            state_in       = S_WAIT_C;
         end
         S_WAIT_C: begin
            cmd.norm_sel = tta_pkg::NSEL_SUM;
            if (stat.norm_done) begin
               cmd.cor_save = 1'b1;
               state_in     = S_EMIT;
            end
         end
         S_EMIT: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               if (corner_ff == tta_pkg::CORNER_C) begin
                  state_in = S_IDLE;
               end else begin
                  corner_in = corner_ff + 1'b1;
                  state_in  = S_RD;
               end
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         corner_ff <= tta_pkg::CORNER_A;
      end else begin
         state_ff  <= state_in;
         corner_ff <= corner_in;
      end
   end

`ifndef SYNTHESIS
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      stat.norm_done |-> (state_ff == S_WAIT_T || state_ff == S_WAIT_C))
      else $error("normaliser finished outside a wait state");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_DELTA))
      else $error("accepted beat did not start the front end");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.rsp_free)
      else $error("result overwritten while still held");
   a_corner_range: assert property (@(posedge clock) disable iff (reset)
      corner_ff != 2'd3)
      else $error("corner counter out of range");
`endif

endmodule
